### sv/bbe_pkg.sv
package bbe_pkg;

  localparam int PIX_W      = 8;
  localparam int RGB_W      = 3 * PIX_W;
  localparam int CSUM_W     = 10;
  localparam int SUM_W      = 12;
  localparam int DIVN_W     = 4;
  localparam int NUM_W      = SUM_W + 1;
  localparam int RECIP_W    = 18;
  localparam int RECIP_SHIFT = 18;
  localparam int ROW_W      = 16;
  localparam int IMG_W_W    = 11;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic [IMG_W_W-1:0] RESET_WIDTH  = IMG_W_W'(640);
  localparam logic [ROW_W-1:0]   RESET_HEIGHT = ROW_W'(480);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    logic [CSUM_W-1:0] red;
    logic [CSUM_W-1:0] green;
    logic [CSUM_W-1:0] blue;
  } csum_t;

  typedef struct packed {
    logic [SUM_W-1:0]  sum_red;
    logic [SUM_W-1:0]  sum_green;
    logic [SUM_W-1:0]  sum_blue;
    logic [DIVN_W-1:0] count;
    logic [ROW_W-1:0]  row;
    logic              last_run;
    logic              frame_end;
  } mean_req_t;

endpackage

### sv/bbe_if.sv
interface bbe_pix_if;
  import bbe_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] blue_in;
  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface bbe_res_if #(parameter int COL_W = 10);
  import bbe_pkg::*;
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic [PIX_W-1:0] red_out;
  logic [PIX_W-1:0] green_out;
  logic [PIX_W-1:0] blue_out;
  logic             last_of_run;
  logic             frame_done;
  modport source (output valid, output out_row, output out_col, output red_out,
                  output green_out, output blue_out, output last_of_run,
                  output frame_done, input ready);
  modport sink (input valid, input out_row, input out_col, input red_out,
                input green_out, input blue_out, input last_of_run,
                input frame_done, output ready);
endinterface

interface bbe_cfg_if;
  import bbe_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### sv/bbe_row_mem.sv
module bbe_row_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 48
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/bbe_mean.sv
module bbe_mean #(
  parameter int COL_W = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  output logic                req_ready,
  input  bbe_pkg::mean_req_t  req,
  input  logic [COL_W-1:0]    req_col,
  bbe_res_if.source           res
);
  import bbe_pkg::*;

  localparam int PROD_W = NUM_W + RECIP_W;

  // The count is always 1, 2, 3, 4, 6 or 9; the reciprocal of twice the
  // count is rounded up so that the product gives the exact floor.
  function automatic logic [RECIP_W-1:0] recip(input logic [DIVN_W-1:0] n);
    logic [RECIP_W-1:0] m;
    unique case (n)
      DIVN_W'(1): m = RECIP_W'(131072);
      DIVN_W'(2): m = RECIP_W'(65536);
      DIVN_W'(3): m = RECIP_W'(43691);
      DIVN_W'(4): m = RECIP_W'(32768);
      DIVN_W'(6): m = RECIP_W'(21846);
      DIVN_W'(9): m = RECIP_W'(14564);
      default:    m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [PIX_W-1:0] mean_of(input logic [SUM_W-1:0]  s,
                                               input logic [DIVN_W-1:0] n);
    logic [NUM_W-1:0]  num;
    logic [PROD_W-1:0] prod;
    num  = {s, 1'b0} + NUM_W'(n);
    prod = PROD_W'(num) * PROD_W'(recip(n));
    return prod[RECIP_SHIFT +: PIX_W];
  endfunction

  logic             s1_valid_r;
  mean_req_t        s1_req_r;
  logic [COL_W-1:0] s1_col_r;
  logic             out_valid_r;
  logic [ROW_W-1:0] out_row_r;
  logic [COL_W-1:0] out_col_r;
  logic [PIX_W-1:0] red_r;
  logic [PIX_W-1:0] green_r;
  logic [PIX_W-1:0] blue_r;
  logic             last_r;
  logic             done_r;
  logic             out_free;
  logic             s1_move;

  assign out_free  = !out_valid_r || res.ready;
  assign s1_move   = s1_valid_r && out_free;
  assign req_ready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (req_ready) begin
      s1_valid_r <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      s1_req_r <= req;
      s1_col_r <= req_col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_row_r <= s1_req_r.row;
      out_col_r <= s1_col_r;
      red_r     <= mean_of(s1_req_r.sum_red, s1_req_r.count);
      green_r   <= mean_of(s1_req_r.sum_green, s1_req_r.count);
      blue_r    <= mean_of(s1_req_r.sum_blue, s1_req_r.count);
      last_r    <= s1_req_r.last_run;
      done_r    <= s1_req_r.frame_end;
    end
  end

  assign res.valid       = out_valid_r;
  assign res.out_row     = out_row_r;
  assign res.out_col     = out_col_r;
  assign res.red_out     = red_r;
  assign res.green_out   = green_r;
  assign res.blue_out    = blue_r;
  assign res.last_of_run = last_r;
  assign res.frame_done  = done_r;

endmodule

### sv/box_blur_3x3_edge_aware.sv
// Channel   Direction  Transaction carries
// in_pix    sink       one RGB pixel in raster order
// out_res   source     one blurred pixel with its row, column and run/frame flags
// cfg_wr    sink       one register write: index 0 image width, index 1 image height
//
// For each accepted pixel, the accept cycle issues the row-store read at the pixel's
// column, the next cycle takes the read data, updates the column sums and writes the
// entry back, then its results are pushed one per cycle while the mean unit takes them.
// Results pass a two-stage mean unit (request register, then reciprocal multiply into
// the output register); a low out_res.ready holds them there and stalls the sequencer.
// Reset is synchronous: position, window and size (640 x 480) are cleared; the row
// store is not cleared and needs no clearing pass.
module box_blur_3x3_edge_aware #(
  parameter int MAX_WIDTH = 1024
) (
  input logic         clk,
  input logic         rst_n,
  bbe_pix_if.sink     in_pix,
  bbe_res_if.source   out_res,
  bbe_cfg_if.sink     cfg_wr
);
  import bbe_pkg::*;

  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int MEM_W = 2 * RGB_W;

  function automatic logic [CW-1:0] last_col_of(input logic [IMG_W_W-1:0] w);
    logic [IMG_W_W+1:0] w_ext;
    logic [CW-1:0]      lc;
    w_ext = {2'b00, w};
    if (w == '0) begin
      lc = '0;
    end else if (w_ext > (IMG_W_W+2)'(MAX_WIDTH)) begin
      lc = CW'(MAX_WIDTH - 1);
    end else begin
      lc = CW'(w_ext - (IMG_W_W+2)'(1));
    end
    return lc;
  endfunction

  function automatic csum_t col_sum(input logic [RGB_W-1:0] cur,
                                    input logic [RGB_W-1:0] prev,
                                    input logic [RGB_W-1:0] older,
                                    input logic             use_prev,
                                    input logic             use_older);
    logic [RGB_W-1:0] p;
    logic [RGB_W-1:0] o;
    csum_t            s;
    p = use_prev ? prev : '0;
    o = use_older ? older : '0;
    s.red   = CSUM_W'(cur[23:16]) + CSUM_W'(p[23:16]) + CSUM_W'(o[23:16]);
    s.green = CSUM_W'(cur[15:8]) + CSUM_W'(p[15:8]) + CSUM_W'(o[15:8]);
    s.blue  = CSUM_W'(cur[7:0]) + CSUM_W'(p[7:0]) + CSUM_W'(o[7:0]);
    return s;
  endfunction

  seq_state_t        state_r;
  seq_state_t        state_nxt;
  logic [3:0]        pend_r;
  logic [3:0]        pend_nxt;
  logic [ROW_W-1:0]  row_r;
  logic [CW-1:0]     col_r;
  logic [ROW_W-1:0]  last_row_r;
  logic [CW-1:0]     last_col_r;
  logic [RGB_W-1:0]  pix_r;
  logic [ROW_W-1:0]  cur_row_r;
  logic [CW-1:0]     cur_col_r;
  csum_t             win_a_r [3];
  csum_t             win_b_r [3];

  logic              in_acc;
  logic              cfg_acc;
  logic              mem_we;
  logic [MEM_W-1:0]  mem_rdata;
  logic [RGB_W-1:0]  rd_prev;
  logic [RGB_W-1:0]  rd_older;
  logic              r_ge1;
  logic              r_ge2;
  logic              c_ge1;
  logic              c_ge2;
  logic              row_end;
  logic              last_row;
  logic [3:0]        sel;
  logic              use_b;
  logic              wide;
  csum_t             win0;
  csum_t             win1;
  csum_t             win2;
  csum_t             left;
  csum_t             mid;
  logic [1:0]        nv;
  logic [1:0]        nh;
  logic              req_valid;
  logic              req_ready;
  mean_req_t         req;
  logic [CW-1:0]     req_col;

  assign in_pix.ready = (state_r == ST_IDLE);
  assign cfg_wr.ready = 1'b1;
  assign in_acc  = in_pix.valid && in_pix.ready;
  assign cfg_acc = cfg_wr.valid && cfg_wr.ready;

  assign r_ge1    = (cur_row_r != '0);
  assign r_ge2    = (cur_row_r > ROW_W'(1));
  assign c_ge1    = (cur_col_r != '0);
  assign c_ge2    = (cur_col_r > CW'(1));
  assign row_end  = (cur_col_r == last_col_r);
  assign last_row = (cur_row_r == last_row_r);

  assign rd_prev  = mem_rdata[MEM_W-1:RGB_W];
  assign rd_older = mem_rdata[RGB_W-1:0];
  assign mem_we   = (state_r == ST_READ);

  // Each entry holds the two rows above the current one at that column.
  bbe_row_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (MEM_W)
  ) u_row_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cur_col_r),
    .wdata ({pix_r, rd_prev}),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    sel       = '0;
    req_valid = 1'b0;
    priority if (pend_r[0]) begin
      sel = 4'b0001;
    end else if (pend_r[1]) begin
      sel = 4'b0010;
    end else if (pend_r[2]) begin
      sel = 4'b0100;
    end else begin
      sel = 4'b1000;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        pend_nxt = {last_row && row_end, last_row && c_ge1,
                    r_ge1 && row_end, r_ge1 && c_ge1};
        state_nxt = (pend_nxt == '0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        req_valid = 1'b1;
        if (req_ready) begin
          pend_nxt = pend_r & ~sel;
          if (pend_nxt == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      last_col_r <= last_col_of(RESET_WIDTH);
      last_row_r <= RESET_HEIGHT - ROW_W'(1);
    end else if (cfg_acc) begin
      if (cfg_wr.index == REG_IMAGE_WIDTH) begin
        last_col_r <= last_col_of(cfg_wr.data[IMG_W_W-1:0]);
        row_r      <= '0;
        col_r      <= '0;
      end else if (cfg_wr.index == REG_IMAGE_HEIGHT) begin
        last_row_r <= (cfg_wr.data == '0) ? '0 : cfg_wr.data - ROW_W'(1);
        row_r      <= '0;
        col_r      <= '0;
      end
    end else if (in_acc) begin
      if (col_r == last_col_r) begin
        col_r <= '0;
        row_r <= (row_r == last_row_r) ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_r     <= {in_pix.red_in, in_pix.green_in, in_pix.blue_in};
      cur_row_r <= row_r;
      cur_col_r <= col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        win_a_r[i] <= '0;
        win_b_r[i] <= '0;
      end
    end else if (state_r == ST_READ) begin
      win_a_r[0] <= win_a_r[1];
      win_a_r[1] <= win_a_r[2];
      win_a_r[2] <= col_sum(pix_r, rd_prev, rd_older, r_ge1, r_ge2);
      win_b_r[0] <= win_b_r[1];
      win_b_r[1] <= win_b_r[2];
      win_b_r[2] <= col_sum(pix_r, rd_prev, rd_older, r_ge1, 1'b0);
    end
  end

  // Results one and three cover columns c-2..c, two and four columns c-1..c;
  // three and four belong to the last row, where no row lies below.
  always_comb begin
    use_b = sel[2] || sel[3];
    wide  = sel[0] || sel[2];
    win0  = use_b ? win_b_r[0] : win_a_r[0];
    win1  = use_b ? win_b_r[1] : win_a_r[1];
    win2  = use_b ? win_b_r[2] : win_a_r[2];
    if (wide) begin
      left = c_ge2 ? win0 : '0;
      mid  = win1;
      nh   = c_ge2 ? 2'd3 : 2'd2;
    end else begin
      left = '0;
      mid  = c_ge1 ? win1 : '0;
      nh   = c_ge1 ? 2'd2 : 2'd1;
    end
    if (use_b) begin
      nv = r_ge1 ? 2'd2 : 2'd1;
    end else begin
      nv = r_ge2 ? 2'd3 : 2'd2;
    end
    req.sum_red   = SUM_W'(left.red) + SUM_W'(mid.red) + SUM_W'(win2.red);
    req.sum_green = SUM_W'(left.green) + SUM_W'(mid.green) + SUM_W'(win2.green);
    req.sum_blue  = SUM_W'(left.blue) + SUM_W'(mid.blue) + SUM_W'(win2.blue);
    req.count     = DIVN_W'(nv) * DIVN_W'(nh);
    req.row       = use_b ? cur_row_r : cur_row_r - ROW_W'(1);
    req.last_run  = ((pend_r & ~sel) == '0);
    req.frame_end = sel[3];
    req_col       = wide ? cur_col_r - CW'(1) : cur_col_r;
  end

  bbe_mean #(
    .COL_W (CW)
  ) u_mean (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .req_col   (req_col),
    .res       (out_res)
  );

endmodule

### dv/box_blur_3x3_edge_aware_test.sv
module box_blur_3x3_edge_aware_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bbe_pkg::*;

  localparam int MAX_COLS = 1024;
  localparam int COL_BITS = 10;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(15);
  localparam logic [RGB_W-1:0] PATTERN [9] = '{
    24'hFFFFFF, 24'h000000, 24'hFF00FF, 24'h00FF00, 24'h010203,
    24'hFEFDFC, 24'h800080, 24'h7F7F7F, 24'h01FF00
  };

  typedef struct packed {
    logic [ROW_W-1:0]    row;
    logic [COL_BITS-1:0] col;
    logic [PIX_W-1:0]    red;
    logic [PIX_W-1:0]    green;
    logic [PIX_W-1:0]    blue;
    logic                last_run;
    logic                frame_end;
  } blur_px_t;

  class blur_tracker;
    logic [RGB_W-1:0] store_a [MAX_COLS];
    logic [RGB_W-1:0] store_b [MAX_COLS];
    logic [RGB_W-1:0] window [3];
    bit               flipped;
    int               row_pos;
    int               col_pos;
    int               width_reg;
    int               height_reg;
    blur_px_t         due [$];
    int               errors;
    int               results_seen;

    function new();
      foreach (store_a[i]) begin
        store_a[i] = '0;
        store_b[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      flipped = 1'b0;
      row_pos = 0;
      col_pos = 0;
      width_reg = 640;
      height_reg = 480;
      errors = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_IMAGE_WIDTH) begin
        width_reg = int'(data[IMG_W_W-1:0]);
      end else if (idx == REG_IMAGE_HEIGHT) begin
        height_reg = int'(data);
      end else begin
        return;
      end
      row_pos = 0;
      col_pos = 0;
    endfunction

    function int active_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_COLS) return MAX_COLS;
      return width_reg;
    endfunction

    function logic [RGB_W-1:0] pixel_at(int y, int x, int r, int c);
      int d;
      d = c - x;
      if (y == r) return (d < 0 || d > 2) ? '0 : window[2-d];
      if (y == r - 1) return flipped ? store_a[x] : store_b[x];
      if (y == r - 2) return flipped ? store_b[x] : store_a[x];
      return '0;
    endfunction

    function void put_older(int x, logic [RGB_W-1:0] px);
      if (flipped) store_b[x] = px;
      else store_a[x] = px;
    endfunction

    function blur_px_t neighborhood_mean(int orow, int ocol, int r, int c, int w, int h);
      int sr, sg, sb, n;
      logic [RGB_W-1:0] p;
      blur_px_t res;
      sr = 0;
      sg = 0;
      sb = 0;
      n = 0;
      for (int y = orow - 1; y <= orow + 1; y++) begin
        if (y < 0 || y > h - 1) continue;
        for (int x = ocol - 1; x <= ocol + 1; x++) begin
          if (x < 0 || x > w - 1) continue;
          p = pixel_at(y, x, r, c);
          sr += p[23:16];
          sg += p[15:8];
          sb += p[7:0];
          n++;
        end
      end
      if (n == 0) n = 1;
      res.row = orow[ROW_W-1:0];
      res.col = ocol[COL_BITS-1:0];
      res.red = PIX_W'((2 * sr + n) / (2 * n));
      res.green = PIX_W'((2 * sg + n) / (2 * n));
      res.blue = PIX_W'((2 * sb + n) / (2 * n));
      res.last_run = 1'b0;
      res.frame_end = (orow == h - 1 && ocol == w - 1);
      return res;
    endfunction

    function void take_pixel(logic [RGB_W-1:0] px);
      int w, h, r, c;
      bit row_end, last_row;
      blur_px_t batch [$];
      w = active_width();
      h = (height_reg == 0) ? 1 : height_reg;
      r = row_pos;
      c = col_pos;
      if (c > w - 1) c = w - 1;
      if (r > h - 1) r = h - 1;
      row_end = (c == w - 1);
      last_row = (r == h - 1);
      window[0] = window[1];
      window[1] = window[2];
      window[2] = px;
      if (r >= 1 && c >= 1) batch.push_back(neighborhood_mean(r - 1, c - 1, r, c, w, h));
      if (r >= 1 && row_end) batch.push_back(neighborhood_mean(r - 1, c, r, c, w, h));
      if (last_row && c >= 1) batch.push_back(neighborhood_mean(r, c - 1, r, c, w, h));
      if (last_row && row_end) batch.push_back(neighborhood_mean(r, c, r, c, w, h));
      if (batch.size() > 0) batch[batch.size() - 1].last_run = 1'b1;
      foreach (batch[i]) due.push_back(batch[i]);
      if (c >= 2) put_older(c - 2, window[0]);
      if (row_end) begin
        if (c >= 1) put_older(c - 1, window[1]);
        put_older(c, window[2]);
        flipped = !flipped;
        col_pos = 0;
        row_pos = last_row ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
        row_pos = r;
      end
    endfunction

    function void check_output(blur_px_t got);
      blur_px_t want;
      results_seen++;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("Unexpected result at row %0d col %0d.", got.row, got.col);
        end
        return;
      end
      want = due.pop_front();
      if (got.row !== want.row || got.col !== want.col || got.red !== want.red ||
          got.green !== want.green || got.blue !== want.blue ||
          got.last_run !== want.last_run || got.frame_end !== want.frame_end) begin
        errors++;
        if (errors <= 10) begin
          $display("Mismatch: wanted row %0d col %0d rgb %h %h %h last %b done %b",
                   want.row, want.col, want.red, want.green, want.blue,
                   want.last_run, want.frame_end);
          $display("          got    row %0d col %0d rgb %h %h %h last %b done %b",
                   got.row, got.col, got.red, got.green, got.blue,
                   got.last_run, got.frame_end);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bbe_pix_if in_pix ();
  bbe_res_if #(.COL_W(COL_BITS)) out_res ();
  bbe_cfg_if cfg_wr ();

  box_blur_3x3_edge_aware #(
    .MAX_WIDTH(MAX_COLS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_pix(in_pix),
    .out_res(out_res),
    .cfg_wr(cfg_wr)
  );

  blur_tracker tracker = new();
  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int pixels_sent = 0;
  int size_settings = 0;
  int pattern_idx = 0;

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (out_res.valid && out_res.ready) begin
      tracker.check_output('{out_res.out_row, out_res.out_col, out_res.red_out,
                             out_res.green_out, out_res.blue_out,
                             out_res.last_of_run, out_res.frame_done});
    end
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_res.ready <= 1'b0;
    end else begin
      out_res.ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_pix.valid && in_pix.ready) || (out_res.valid && out_res.ready) ||
        (cfg_wr.valid && cfg_wr.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles.", QUIET_LIMIT);
      $display("box_blur_3x3_edge_aware_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pixel(input logic [RGB_W-1:0] px);
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_pix.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_pix.valid <= 1'b1;
    in_pix.red_in <= px[23:16];
    in_pix.green_in <= px[15:8];
    in_pix.blue_in <= px[7:0];
    do @(posedge clk); while (!in_pix.ready);
    tracker.take_pixel(px);
    pixels_sent++;
  endtask

  task automatic stream_random(input int count);
    repeat (count) send_pixel(RGB_W'($urandom()));
  endtask

  task automatic send_pattern(input int count);
    repeat (count) begin
      send_pixel(PATTERN[pattern_idx % 9]);
      pattern_idx++;
    end
  endtask

  task automatic drain();
    in_pix.valid <= 1'b0;
    while (tracker.due.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data, input bit last);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data <= data;
    do @(posedge clk); while (!cfg_wr.ready);
    tracker.write_reg(idx, data);
    if (last) cfg_wr.valid <= 1'b0;
  endtask

  task automatic set_size(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    drain();
    program_reg(REG_IMAGE_WIDTH, w, 1'b0);
    program_reg(REG_IMAGE_HEIGHT, h, 1'b1);
    size_settings++;
  endtask

  task automatic random_frames();
    int w, h, n;
    w = $urandom_range(1, 6);
    h = $urandom_range(1, 3);
    n = w * h;
    if ($urandom_range(3) == 0) n += $urandom_range(1, w);
    set_size(CFG_DATA_W'(w), CFG_DATA_W'(h));
    stream_random(n);
  endtask

  initial begin
    in_pix.valid = 1'b0;
    in_pix.red_in = '0;
    in_pix.green_in = '0;
    in_pix.blue_in = '0;
    out_res.ready = 1'b0;
    cfg_wr.valid = 1'b0;
    cfg_wr.index = '0;
    cfg_wr.data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_gap_pct = 22;
    recv_gap_pct = 56;
    stream_random(4);

    set_size(CFG_DATA_W'(3), CFG_DATA_W'(3));
    send_pattern(4);
    drain();
    program_reg(REG_SPARE, 16'h0001, 1'b1);
    send_pattern(5);
    set_size(CFG_DATA_W'(1), CFG_DATA_W'(1));
    send_pattern(2);
    set_size(CFG_DATA_W'(1), CFG_DATA_W'(3));
    send_pattern(2);
    drain();
    program_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(3), 1'b1);
    send_pattern(3);
    set_size(CFG_DATA_W'(3), CFG_DATA_W'(1));
    send_pattern(3);
    set_size('0, '0);
    send_pattern(1);
    random_frames();

    send_gap_pct = 56;
    recv_gap_pct = 22;
    set_size(16'hF803, 16'hFFFF);
    stream_random(10);
    random_frames();
    set_size(16'h07FF, CFG_DATA_W'(1));
    stream_random(8);

    send_gap_pct = 0;
    recv_gap_pct = 0;
    set_size(CFG_DATA_W'(6), CFG_DATA_W'(3));
    stream_random(4);
    hold_request = 1'b1;
    stream_random(14);
    drain();
    stream_random(12);
    random_frames();

    in_pix.valid <= 1'b0;
    while (tracker.due.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d pixels over %0d size settings, checked %0d blurred pixels.",
             pixels_sent, size_settings, tracker.results_seen);
    $display("Mismatches: %0d.", tracker.errors);
    if (tracker.errors == 0) begin
      $display("box_blur_3x3_edge_aware_test: PASS");
    end else begin
      $display("box_blur_3x3_edge_aware_test: FAIL");
    end
    $finish;
  end

endmodule
